### rtl/core/tlb_pkg.sv
// Shared types and constants for the fully associative TLB.
package tlb_pkg;

  // Number of entries; the slot index width follows from it.
  localparam int ENTRIES   = 16;
  localparam int SLOT_BITS = $clog2(ENTRIES);

  // Field widths fixed by the item format.
  localparam int PAGE_BITS  = 8;
  localparam int FRAME_BITS = 8;
  localparam int AGE_BITS   = 16;

  // Configuration port geometry.
  localparam int ADDR_BITS = 3;
  localparam int DATA_BITS = 32;

  // Saturation value of an entry's age.
  localparam logic [AGE_BITS-1:0] AGE_MAX = {AGE_BITS{1'b1}};

  // Operation codes.
  localparam logic CMD_LOOKUP = 1'b0;
  localparam logic CMD_FILL   = 1'b1;

  // Replacement modes.
  localparam logic MODE_FIFO = 1'b0;
  localparam logic MODE_LRU  = 1'b1;

  // Register index of the replacement mode.
  localparam logic REG_REPLACE_MODE = 1'b0;

  // Input word.
  typedef struct packed {
    logic                  cmd;
    logic [PAGE_BITS-1:0]  page_number;
    logic [FRAME_BITS-1:0] fill_frame;
  } tlb_req_t;

  // Output word.
  typedef struct packed {
    logic                  hit;
    logic [FRAME_BITS-1:0] frame_number;
    logic [SLOT_BITS-1:0]  slot_used;
  } tlb_rsp_t;

  // Token that travels down the chain of entry cells.
  typedef struct packed {
    logic                  active;
    logic                  cmd;
    logic [PAGE_BITS-1:0]  page;
    logic [FRAME_BITS-1:0] frame;
    logic                  found;
    logic [SLOT_BITS-1:0]  slot;
    logic                  inv_found;
    logic [SLOT_BITS-1:0]  inv_slot;
    logic [AGE_BITS-1:0]   best_age;
    logic [SLOT_BITS-1:0]  best_slot;
  } tlb_tok_t;

  // Broadcast control from the top level to every cell.
  typedef struct packed {
    logic                  age_en;
    logic                  wr_en;
    logic [SLOT_BITS-1:0]  wr_slot;
    logic [PAGE_BITS-1:0]  wr_page;
    logic [FRAME_BITS-1:0] wr_frame;
  } tlb_ctrl_t;

endpackage

### rtl/core/tlb_cell.sv
// One TLB entry cell: holds an entry and updates the passing search token.
module tlb_cell #(
  parameter int INDEX = 0
) (
  input  logic               clk,
  input  logic               rst,
  input  tlb_pkg::tlb_tok_t  tok_in,
  input  tlb_pkg::tlb_ctrl_t ctrl,
  output tlb_pkg::tlb_tok_t  tok_out
);
  import tlb_pkg::*;

  localparam logic [SLOT_BITS-1:0] MY_SLOT = SLOT_BITS'(INDEX);

  logic [PAGE_BITS-1:0]  page;
  logic [FRAME_BITS-1:0] frame;
  logic                  valid;
  logic [AGE_BITS-1:0]   age;
  tlb_tok_t              tok_next;
  logic                  match;
  logic                  wr_here;

  // A lookup claims this entry when no lower entry has matched.
  assign match = tok_in.active && (tok_in.cmd == CMD_LOOKUP) && !tok_in.found &&
                 valid && (page == tok_in.page);
  assign wr_here = ctrl.wr_en && (ctrl.wr_slot == MY_SLOT);

  // Token update: record a hit, the first free entry and the oldest entry.
  always_comb begin
    tok_next = tok_in;
    if (match) begin
      tok_next.found = 1'b1;
      tok_next.frame = frame;
      tok_next.slot  = MY_SLOT;
    end
    if (tok_in.active && (tok_in.cmd == CMD_FILL)) begin
      if (!valid && !tok_in.inv_found) begin
        tok_next.inv_found = 1'b1;
        tok_next.inv_slot  = MY_SLOT;
      end
      if (age > tok_in.best_age) begin
        tok_next.best_age  = age;
        tok_next.best_slot = MY_SLOT;
      end
    end
  end

  // Hand the token on to the next cell.
  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out.active <= 1'b0;
    end else begin
      tok_out <= tok_next;
    end
  end

  // Entry state: validity and age are cleared by reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      age   <= '0;
    end else if (wr_here) begin
      valid <= 1'b1;
      age   <= '0;
    end else if (match) begin
      age <= '0;
    end else if (ctrl.age_en && (age != AGE_MAX)) begin
      age <= age + 1'b1;
    end
  end

  // Page and frame are only read once the entry is valid.
  always_ff @(posedge clk) begin
    if (wr_here) begin
      page  <= ctrl.wr_page;
      frame <= ctrl.wr_frame;
    end
  end

endmodule

### rtl/core/tlb_lookup_fill_fifo_lru.sv
// Top level of the fully associative TLB with FIFO or LRU replacement.
// One word is in flight at a time: a new word waits until the search token that
// walks the chain of entry cells, one cell per cycle, has left the last cell and
// the skid word is empty.
// Reset (synchronous, active high) invalidates all entries, zeroes all ages,
// the FIFO pointer and the replacement mode; no clearing pass is needed.
module tlb_lookup_fill_fifo_lru (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           req_valid,
  output logic                           req_stall,
  input  tlb_pkg::tlb_req_t              req,
  output logic                           rsp_valid,
  input  logic                           rsp_stall,
  output tlb_pkg::tlb_rsp_t              rsp,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [tlb_pkg::ADDR_BITS-1:0]  paddr,
  input  logic [tlb_pkg::DATA_BITS-1:0]  pwdata,
  output logic [tlb_pkg::DATA_BITS-1:0]  prdata,
  output logic                           pready
);
  import tlb_pkg::*;

  localparam logic [SLOT_BITS-1:0] LAST_SLOT = SLOT_BITS'(ENTRIES - 1);

  tlb_tok_t             head;
  tlb_tok_t             link [0:ENTRIES];
  tlb_tok_t             tail;
  tlb_ctrl_t            ctrl;
  logic [ENTRIES-1:0]   act_vec;
  logic                 busy;
  logic                 replace_mode;
  logic [SLOT_BITS-1:0] fifo_ptr;
  logic                 pend_valid;
  tlb_rsp_t             pend;
  tlb_rsp_t             res;
  logic                 acc;
  logic                 rsp_free;
  logic                 reg_sel;
  logic                 cfg_wr;
  logic                 fill_done;
  logic                 use_fifo;
  logic [SLOT_BITS-1:0] fill_slot;

  // Configuration port: a single mode register at address zero.
  assign pready  = 1'b1;
  assign reg_sel = (paddr[ADDR_BITS-1:2] == REG_REPLACE_MODE);
  assign cfg_wr  = psel && penable && pwrite && pready && reg_sel;
  assign prdata  = reg_sel ? {{(DATA_BITS-1){1'b0}}, replace_mode} : '0;

  // One word is in flight at a time; a waiting result holds in the skid word.
  assign req_stall = busy || pend_valid;
  assign acc       = req_valid && !req_stall;
  assign rsp_free  = !rsp_valid || !rsp_stall;

  // Chain of entry cells, fed by the head register.
  assign link[0] = head;
  assign tail    = link[ENTRIES];

  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    tlb_cell #(
      .INDEX(i)
    ) u_cell (
      .clk    (clk),
      .rst    (rst),
      .tok_in (link[i]),
      .ctrl   (ctrl),
      .tok_out(link[i+1])
    );
    assign act_vec[i] = link[i+1].active;
  end

  // Victim choice once the token has seen every entry.
  assign fill_done = tail.active && (tail.cmd == CMD_FILL);
  assign use_fifo  = !tail.inv_found && (replace_mode == MODE_FIFO);

  always_comb begin
    if (tail.inv_found) begin
      fill_slot = tail.inv_slot;
    end else if (replace_mode == MODE_LRU) begin
      fill_slot = tail.best_slot;
    end else begin
      fill_slot = fifo_ptr;
    end
  end

  // Broadcast to the cells: ageing at a lookup's acceptance, write at fill end.
  assign ctrl.age_en   = acc && (req.cmd == CMD_LOOKUP);
  assign ctrl.wr_en    = fill_done;
  assign ctrl.wr_slot  = fill_slot;
  assign ctrl.wr_page  = tail.page;
  assign ctrl.wr_frame = tail.frame;

  // Result word from the finished token.
  always_comb begin
    res = '0;
    if (tail.cmd == CMD_LOOKUP) begin
      if (tail.found) begin
        res.hit          = 1'b1;
        res.frame_number = tail.frame;
        res.slot_used    = tail.slot;
      end
    end else begin
      res.slot_used = fill_slot;
    end
  end

  // Launch a fresh token at the head of the chain.
  always_ff @(posedge clk) begin
    if (rst) begin
      head.active <= 1'b0;
    end else begin
      head.active <= acc;
      if (acc) begin
        head.cmd       <= req.cmd;
        head.page      <= req.page_number;
        head.frame     <= (req.cmd == CMD_FILL) ? req.fill_frame : '0;
        head.found     <= 1'b0;
        head.slot      <= '0;
        head.inv_found <= 1'b0;
        head.inv_slot  <= '0;
        head.best_age  <= '0;
        head.best_slot <= '0;
      end
    end
  end

  // Control state, mode register and FIFO pointer.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy         <= 1'b0;
      replace_mode <= MODE_FIFO;
      fifo_ptr     <= '0;
    end else begin
      if (acc) begin
        busy <= 1'b1;
      end else if (tail.active) begin
        busy <= 1'b0;
      end
      if (cfg_wr) begin
        replace_mode <= pwdata[0];
      end
      if (fill_done && use_fifo) begin
        fifo_ptr <= (fifo_ptr == LAST_SLOT) ? '0 : fifo_ptr + 1'b1;
      end
    end
  end

  // Output register with a skid word behind it.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid  <= 1'b0;
      pend_valid <= 1'b0;
    end else if (pend_valid) begin
      if (rsp_free) begin
        rsp        <= pend;
        rsp_valid  <= 1'b1;
        pend_valid <= 1'b0;
      end
    end else if (tail.active) begin
      if (rsp_free) begin
        rsp       <= res;
        rsp_valid <= 1'b1;
      end else begin
        pend       <= res;
        pend_valid <= 1'b1;
      end
    end else if (rsp_valid && !rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  // At most one token walks the chain, and only while the block is busy.
  a_one_token: assert property (@(posedge clk) disable iff (rst)
    $countones(act_vec) <= 1)
    else $error("more than one search token in the cell chain");

  a_token_busy: assert property (@(posedge clk) disable iff (rst)
    (act_vec != '0) |-> busy)
    else $error("search token present while the block is idle");

  // A finished search never meets a full skid word.
  a_tail_pend: assert property (@(posedge clk) disable iff (rst)
    tail.active |-> !pend_valid)
    else $error("search finished while a result was still held back");

  // The skid word is only used while the output register is occupied.
  a_pend_out: assert property (@(posedge clk) disable iff (rst)
    pend_valid |-> rsp_valid)
    else $error("held result without a result at the output");

endmodule
